// ----- design/ssep_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SSE parser package
// Shared types, codes and name tables for the event stream parser blocks.
// ----------------------------------------------------------------------------
package ssep_pkg;

  // Operation codes passed from the front end to the parser.
  localparam logic [1:0] OP_CHAR  = 2'd0;
  localparam logic [1:0] OP_NL    = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  // Result kinds.
  localparam logic [2:0] K_EVENT_START = 3'd0;
  localparam logic [2:0] K_EVENT_BYTE  = 3'd1;
  localparam logic [2:0] K_DATA_BYTE   = 3'd2;
  localparam logic [2:0] K_ID_START    = 3'd3;
  localparam logic [2:0] K_ID_BYTE     = 3'd4;
  localparam logic [2:0] K_RETRY_SET   = 3'd5;
  localparam logic [2:0] K_RETRY_CLEAR = 3'd6;
  localparam logic [2:0] K_DISPATCH    = 3'd7;

  // Line phases.
  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_NAME    = 3'd1;
  localparam logic [2:0] PH_VALUE   = 3'd2;
  localparam logic [2:0] PH_COMMENT = 3'd3;
  localparam logic [2:0] PH_SKIP    = 3'd4;

  // Field codes.
  localparam logic [2:0] F_EVENT = 3'd0;
  localparam logic [2:0] F_DATA  = 3'd1;
  localparam logic [2:0] F_ID    = 3'd2;
  localparam logic [2:0] F_RETRY = 3'd3;
  localparam logic [2:0] F_NONE  = 3'd4;

  // Retry number parser states.
  localparam logic [2:0] RP_LEAD   = 3'd0;
  localparam logic [2:0] RP_SIGN   = 3'd1;
  localparam logic [2:0] RP_DIGITS = 3'd2;
  localparam logic [2:0] RP_DONE   = 3'd3;
  localparam logic [2:0] RP_FAIL   = 3'd4;
  localparam logic [2:0] RP_OVER   = 3'd5;

  // Character codes.
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Largest accumulator that may still take one more digit without overflow.
  // The low threshold applies to digits above 7 (positive) or above 8 (negative).
  localparam logic [63:0] RETRY_THR_HI = 64'd922337203685477580;
  localparam logic [63:0] RETRY_THR_LO = 64'd922337203685477579;

  // Classified item from the front end.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
    logic       is_colon;
    logic       is_space;
    logic       is_blank;
    logic       is_digit;
  } op_t;

  // Field name match progress.
  typedef struct packed {
    logic       bad;
    logic [1:0] cand;
    logic [2:0] len;
  } nm_t;

  localparam nm_t NM_EMPTY = '{bad: 1'b0, cand: 2'd0, len: 3'd0};

  // One result item.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  value_byte;
    logic [63:0] retry_value;
    logic        last;
  } result_t;

  // Up to two results caused by one operation.
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } pair_t;

  // Length of each recognized field name.
  function automatic logic [2:0] name_len(input logic [1:0] cand);
    logic [2:0] l;
    case (cand)
      2'd0:    l = 3'd5;
      2'd1:    l = 3'd4;
      2'd2:    l = 3'd2;
      default: l = 3'd5;
    endcase
    return l;
  endfunction

  // Character of a recognized field name at a given position.
  function automatic logic [7:0] name_char(input logic [1:0] cand, input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case (cand)
      2'd0: begin
        case (idx)
          3'd0: c = "e";
          3'd1: c = "v";
          3'd2: c = "e";
          3'd3: c = "n";
          3'd4: c = "t";
          default: c = 8'h00;
        endcase
      end
      2'd1: begin
        case (idx)
          3'd0: c = "d";
          3'd1: c = "a";
          3'd2: c = "t";
          3'd3: c = "a";
          default: c = 8'h00;
        endcase
      end
      2'd2: begin
        case (idx)
          3'd0: c = "i";
          3'd1: c = "d";
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (idx)
          3'd0: c = "r";
          3'd1: c = "e";
          3'd2: c = "t";
          3'd3: c = "r";
          3'd4: c = "y";
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  // Advance the name match by one character.
  function automatic nm_t name_step(input nm_t nm, input logic [7:0] c);
    nm_t q;
    q = nm;
    if (nm.bad) begin
      q = nm;
    end else if (nm.len == 3'd0) begin
      q.len = 3'd1;
      if (c == name_char(2'd0, 3'd0)) q.cand = 2'd0;
      else if (c == name_char(2'd1, 3'd0)) q.cand = 2'd1;
      else if (c == name_char(2'd2, 3'd0)) q.cand = 2'd2;
      else if (c == name_char(2'd3, 3'd0)) q.cand = 2'd3;
      else q.bad = 1'b1;
    end else if (nm.len < name_len(nm.cand) && name_char(nm.cand, nm.len) == c) begin
      q.len = nm.len + 3'd1;
    end else begin
      q.bad = 1'b1;
    end
    return q;
  endfunction

  // Field recognized by a completed name, or none.
  function automatic logic [2:0] name_field(input nm_t nm);
    logic [2:0] f;
    if (nm.bad || nm.len == 3'd0) f = F_NONE;
    else if (nm.len == name_len(nm.cand)) f = {1'b0, nm.cand};
    else f = F_NONE;
    return f;
  endfunction

endpackage
`default_nettype wire

// ----- design/ssep_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SSE parser front end
// Accepts stream items, folds CR and CRLF into one newline and classifies
// each byte for the parser.
// ----------------------------------------------------------------------------
module ssep_front import ssep_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_ready,
  input  wire logic       mode,
  input  wire logic [7:0] byte_req,
  output logic            op_valid,
  input  wire logic       op_ready,
  output op_t             op_data
);

  logic pending_cr;
  logic pending_cr_next;
  logic drop;
  logic accept;

  // An LF right after a CR carries no meaning and produces no operation.
  assign drop      = !mode && byte_req == CH_LF && pending_cr;
  assign req_ready = op_ready;
  assign op_valid  = req_valid && !drop;
  assign accept    = req_valid && req_ready;

  // Classify the item.
  always_comb begin
    op_data.ch       = byte_req;
    op_data.is_colon = byte_req == CH_COLON;
    op_data.is_space = byte_req == CH_SPACE;
    op_data.is_blank = byte_req == CH_SPACE || byte_req == CH_TAB ||
                       byte_req == CH_VT || byte_req == CH_FF;
    op_data.is_digit = byte_req >= CH_ZERO && byte_req <= CH_NINE;
    if (mode) op_data.op = OP_FLUSH;
    else if (byte_req == CH_CR || byte_req == CH_LF) op_data.op = OP_NL;
    else op_data.op = OP_CHAR;
  end

  // Remember a CR so that a following LF is dropped.
  always_comb begin
    pending_cr_next = pending_cr;
    if (accept) pending_cr_next = !mode && byte_req == CH_CR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_cr <= 1'b0;
    end else begin
      pending_cr <= pending_cr_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/ssep_op_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SSE parser operation queue
// Two-entry queue of classified items between the front end and the parser.
// ----------------------------------------------------------------------------
module ssep_op_queue import ssep_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire op_t  push_data,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output op_t       pop_data
);

  op_t        entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  assign push_ready = cnt != 2'd2;
  assign pop_valid  = cnt != 2'd0;
  assign pop_data   = entries[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= push_data;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("operation queue count out of range");

endmodule
`default_nettype wire

// ----- design/ssep_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SSE parser back end
// Carries out one classified item per cycle while its four-entry result queue
// has room for two: line phases, field name match, retry number parse, dispatch.
// ----------------------------------------------------------------------------
module ssep_back import ssep_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         op_valid,
  output logic              op_ready,
  input  wire op_t          op_data,
  output logic              rsp_valid,
  input  wire logic         rsp_ready,
  output logic [2:0]        kind,
  output logic [7:0]        value_byte,
  output logic signed [63:0] retry_value,
  output logic              last
);

  // Parser state.
  logic [2:0]  phase;
  logic [2:0]  phase_next;
  nm_t         nm;
  nm_t         nm_next;
  logic        vfc;
  logic        vfc_next;
  logic        seen;
  logic        seen_next;
  logic        dne;
  logic        dne_next;
  logic [63:0] acc;
  logic [63:0] acc_next;
  logic [2:0]  rps;
  logic [2:0]  rps_next;
  logic        neg;
  logic        neg_next;

  // Result queue.
  result_t     oq [4];
  logic [1:0]  wptr;
  logic [1:0]  rptr;
  logic [2:0]  cnt;
  logic        op_pop;
  logic        rsp_pop;
  pair_t       rp;

  // Working values.
  logic [2:0]  f;
  logic [3:0]  d;
  logic [63:0] thr;
  logic [63:0] acc_x10;
  logic [63:0] rv_out;
  logic        end_now;

  function automatic pair_t emit(input pair_t p, input logic [2:0] k,
                                 input logic [7:0] b, input logic [63:0] v);
    pair_t   q;
    result_t r;
    q = p;
    r.kind        = k;
    r.value_byte  = b;
    r.retry_value = v;
    r.last        = 1'b0;
    if (p.n == 2'd0) q.r0 = r;
    else q.r1 = r;
    q.n = p.n + 2'd1;
    return q;
  endfunction

  // A recognized field opens: event and id restart their value, data joins lines.
  function automatic pair_t open_field(input pair_t p, input logic [2:0] fld,
                                       input logic data_ne);
    pair_t q;
    q = p;
    if (fld == F_EVENT) q = emit(p, K_EVENT_START, 8'h00, 64'd0);
    else if (fld == F_ID) q = emit(p, K_ID_START, 8'h00, 64'd0);
    else if (fld == F_DATA && data_ne) q = emit(p, K_DATA_BYTE, CH_LF, 64'd0);
    return q;
  endfunction

  // Take an item only while the result queue has room for two results.
  assign op_pop   = op_valid && cnt <= 3'd2;
  assign op_ready = cnt <= 3'd2;

  // Retry digit arithmetic.
  always_comb begin
    f = name_field(nm);
    d = op_data.ch[3:0];
    if (neg) thr = (d <= 4'd8) ? RETRY_THR_HI : RETRY_THR_LO;
    else thr = (d <= 4'd7) ? RETRY_THR_HI : RETRY_THR_LO;
    acc_x10 = {acc[60:0], 3'b000} + {acc[62:0], 1'b0} + {60'd0, d};
    rv_out  = neg ? (64'd0 - acc) : acc;
  end

  // Parser step.
  always_comb begin
    phase_next = phase;
    nm_next    = nm;
    vfc_next   = vfc;
    seen_next  = seen;
    dne_next   = dne;
    acc_next   = acc;
    rps_next   = rps;
    neg_next   = neg;
    rp         = '0;
    end_now    = 1'b0;

    unique case (op_data.op)
      OP_NL: begin
        if (phase == PH_START) begin
          if (seen) rp = emit(rp, K_DISPATCH, 8'h00, 64'd0);
          seen_next = 1'b0;
          dne_next  = 1'b0;
        end else begin
          end_now = 1'b1;
        end
      end
      OP_FLUSH: begin
        end_now = phase != PH_START;
      end
      OP_CHAR: begin
        unique case (phase)
          PH_START: begin
            if (op_data.is_colon) begin
              phase_next = PH_COMMENT;
            end else begin
              phase_next = PH_NAME;
              nm_next    = name_step(NM_EMPTY, op_data.ch);
            end
          end
          PH_NAME: begin
            if (op_data.is_colon) begin
              if (f == F_NONE) begin
                phase_next = PH_SKIP;
              end else begin
                seen_next = 1'b1;
                rp = open_field(rp, f, dne);
                if (f == F_RETRY) begin
                  acc_next = 64'd0;
                  neg_next = 1'b0;
                  rps_next = RP_LEAD;
                end
                phase_next = PH_VALUE;
                vfc_next   = 1'b1;
              end
            end else begin
              nm_next = name_step(nm, op_data.ch);
            end
          end
          PH_VALUE: begin
            vfc_next = 1'b0;
            if (!(vfc && op_data.is_space)) begin
              if (f == F_EVENT) begin
                rp = emit(rp, K_EVENT_BYTE, op_data.ch, 64'd0);
              end else if (f == F_DATA) begin
                rp = emit(rp, K_DATA_BYTE, op_data.ch, 64'd0);
                dne_next = 1'b1;
              end else if (f == F_ID) begin
                rp = emit(rp, K_ID_BYTE, op_data.ch, 64'd0);
              end else if (f == F_RETRY) begin
                // Retry number: blanks, sign, then one run of digits.
                unique case (rps) inside
                  RP_LEAD: begin
                    if (op_data.is_blank) begin
                      rps_next = RP_LEAD;
                    end else if (op_data.ch == CH_PLUS) begin
                      rps_next = RP_SIGN;
                    end else if (op_data.ch == CH_MINUS) begin
                      neg_next = 1'b1;
                      rps_next = RP_SIGN;
                    end else if (op_data.is_digit) begin
                      if (acc > thr) rps_next = RP_OVER;
                      else begin
                        acc_next = acc_x10;
                        rps_next = RP_DIGITS;
                      end
                    end else begin
                      rps_next = RP_FAIL;
                    end
                  end
                  RP_SIGN, RP_DIGITS: begin
                    if (op_data.is_digit) begin
                      if (acc > thr) rps_next = RP_OVER;
                      else begin
                        acc_next = acc_x10;
                        rps_next = RP_DIGITS;
                      end
                    end else begin
                      rps_next = (rps == RP_SIGN) ? RP_FAIL : RP_DONE;
                    end
                  end
                  default: rps_next = rps;
                endcase
              end
            end
          end
          default: phase_next = phase;
        endcase
      end
      default: phase_next = phase;
    endcase

    // End of a line that holds something.
    if (end_now) begin
      if (phase == PH_NAME && f != F_NONE) begin
        seen_next = 1'b1;
        rp = open_field(rp, f, dne);
        if (f == F_RETRY) rp = emit(rp, K_RETRY_CLEAR, 8'h00, 64'd0);
      end else if (phase == PH_VALUE && f == F_RETRY) begin
        if (rps == RP_DIGITS || rps == RP_DONE) rp = emit(rp, K_RETRY_SET, 8'h00, rv_out);
        else rp = emit(rp, K_RETRY_CLEAR, 8'h00, 64'd0);
      end
      phase_next = PH_START;
      nm_next    = NM_EMPTY;
      vfc_next   = 1'b0;
    end

    // End of stream dispatches any pending event and returns to the reset state.
    if (op_data.op == OP_FLUSH) begin
      if (seen_next) rp = emit(rp, K_DISPATCH, 8'h00, 64'd0);
      phase_next = PH_START;
      nm_next    = NM_EMPTY;
      vfc_next   = 1'b0;
      seen_next  = 1'b0;
      dne_next   = 1'b0;
      acc_next   = 64'd0;
      rps_next   = RP_LEAD;
      neg_next   = 1'b0;
    end

    // Mark the final result of this item.
    if (rp.n == 2'd2) rp.r1.last = 1'b1;
    else if (rp.n == 2'd1) rp.r0.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      nm    <= NM_EMPTY;
      vfc   <= 1'b0;
      seen  <= 1'b0;
      dne   <= 1'b0;
      acc   <= 64'd0;
      rps   <= RP_LEAD;
      neg   <= 1'b0;
    end else if (op_pop) begin
      phase <= phase_next;
      nm    <= nm_next;
      vfc   <= vfc_next;
      seen  <= seen_next;
      dne   <= dne_next;
      acc   <= acc_next;
      rps   <= rps_next;
      neg   <= neg_next;
    end
  end

  // Result queue: up to two writes and one read per cycle.
  assign rsp_valid   = cnt != 3'd0;
  assign rsp_pop     = rsp_valid && rsp_ready;
  assign kind        = oq[rptr].kind;
  assign value_byte  = oq[rptr].value_byte;
  assign retry_value = $signed(oq[rptr].retry_value);
  assign last        = oq[rptr].last;

  always_ff @(posedge clk) begin
    if (op_pop && rp.n != 2'd0) oq[wptr] <= rp.r0;
    if (op_pop && rp.n == 2'd2) oq[wptr + 2'd1] <= rp.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 2'd0;
      rptr <= 2'd0;
      cnt  <= 3'd0;
    end else begin
      if (op_pop) wptr <= wptr + rp.n;
      if (rsp_pop) rptr <= rptr + 2'd1;
      cnt <= cnt + (op_pop ? {1'b0, rp.n} : 3'd0) - {2'b00, rsp_pop};
    end
  end

  a_oq_bound: assert property (@(posedge clk) disable iff (rst) cnt <= 3'd4)
    else $error("result queue overflow");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (op_pop && op_data.op == OP_FLUSH) |=> (phase == PH_START && !seen && rps == RP_LEAD))
    else $error("end of stream did not return the parser to its reset state");

  a_dispatch_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && kind == K_DISPATCH) |-> last)
    else $error("dispatch is not the final result of its item");

endmodule
`default_nettype wire

// ----- design/sse_event_stream_parser_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SSE event stream parser
// Parses a byte stream into tagged field bytes, retry updates and dispatches.
//
//   Channel  Handshake              Payload
//   request  req_valid/req_ready    mode, byte_req
//   result   rsp_valid/rsp_ready    kind, value_byte, retry_value, last
//
// Takes one item per cycle unless a queue is full; an item gives zero, one
// or two results, and the result side drains one result per cycle, so items
// that give two results hold the result side longer. Each item is registered
// in the item queue and then in the result queue before a result is offered.
// Reset is synchronous and empties both queues; there is no clearing pass.
// The two-entry item queue and the four-entry result queue let the request
// and result sides stall independently.
// ----------------------------------------------------------------------------
module sse_event_stream_parser_core import ssep_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         req_valid,
  output logic              req_ready,
  input  wire logic         mode,
  input  wire logic [7:0]   byte_req,
  output logic              rsp_valid,
  input  wire logic         rsp_ready,
  output logic [2:0]        kind,
  output logic [7:0]        value_byte,
  output logic signed [63:0] retry_value,
  output logic              last
);

  logic f_valid;
  logic f_ready;
  op_t  f_op;
  logic q_valid;
  logic q_ready;
  op_t  q_op;

  // Byte normalization and classification.
  ssep_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .mode      (mode),
    .byte_req  (byte_req),
    .op_valid  (f_valid),
    .op_ready  (f_ready),
    .op_data   (f_op)
  );

  // Decoupling queue.
  ssep_op_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_op),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_op)
  );

  // Line parser and result queue.
  ssep_back u_back (
    .clk         (clk),
    .rst         (rst),
    .op_valid    (q_valid),
    .op_ready    (q_ready),
    .op_data     (q_op),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .kind        (kind),
    .value_byte  (value_byte),
    .retry_value (retry_value),
    .last        (last)
  );

endmodule
`default_nettype wire
